[sv/x86e_pkg.sv]
`default_nettype none
package x86e_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;

	localparam logic [3:0] K_MOV    = 4'd0;
	localparam logic [3:0] K_ADD    = 4'd1;
	localparam logic [3:0] K_SUB    = 4'd2;
	localparam logic [3:0] K_CMP    = 4'd3;
	localparam logic [3:0] K_JNE    = 4'd4;
	localparam logic [3:0] K_JE     = 4'd5;
	localparam logic [3:0] K_JP     = 4'd6;
	localparam logic [3:0] K_JB     = 4'd7;
	localparam logic [3:0] K_LOOPNZ = 4'd8;

	localparam logic [1:0] OP_REG  = 2'd0;
	localparam logic [1:0] OP_MEM  = 2'd1;
	localparam logic [1:0] OP_IMM  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_DEST = 2'd1;
	localparam logic [1:0] ERR_MOD3 = 2'd2;

	localparam logic [1:0] MOD_REG = 2'd3;
	localparam logic [2:0] RM_DIRECT = 3'b110;

	localparam int F_CF = 0;
	localparam int F_PF = 1;
	localparam int F_AF = 2;
	localparam int F_ZF = 3;
	localparam int F_SF = 4;
	localparam int F_OF = 5;

	typedef logic [11:0][15:0] regs_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic        wide;
		logic [1:0]  dest_kind;
		logic [3:0]  dest_reg;
		logic [1:0]  src_kind;
		logic [3:0]  src_reg;
		logic [1:0]  mod_bits;
		logic [2:0]  rm_bits;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  instr_length;
	} item_t;

	typedef struct packed {
		logic [15:0] new_ip;
		logic [5:0]  flags_out;
		logic [15:0] old_value;
		logic [15:0] new_value;
		logic        branch_taken;
		logic [4:0]  cycle_cost;
		logic [31:0] clock_total;
		logic [1:0]  error_code;
		logic        reg_we;
		logic        mem_we;
		logic        cx_we;
	} exec_t;

	function automatic logic [15:0] reg_rd(regs_t r, logic [3:0] idx, logic wide);
		logic [15:0] v;
		v = 16'd0;
		if (idx < 4'd8) begin
			if (wide) v = r[idx];
			else if (idx < 4'd4) v = {8'd0, r[idx][7:0]};
			else v = {8'd0, r[idx - 4'd4][15:8]};
		end else if (idx < 4'd12) begin
			v = wide ? r[idx] : {8'd0, r[idx][7:0]};
		end
		return v;
	endfunction

	function automatic regs_t reg_wr(regs_t r, logic [3:0] idx, logic wide, logic [15:0] v);
		regs_t o;
		o = r;
		if (idx < 4'd8) begin
			if (wide) o[idx] = v;
			else if (idx < 4'd4) o[idx][7:0] = v[7:0];
			else o[idx - 4'd4][15:8] = v[7:0];
		end else if (idx < 4'd12) begin
			if (wide) o[idx] = v;
			else o[idx][7:0] = v[7:0];
		end
		return o;
	endfunction

	function automatic logic [15:0] eff_addr(regs_t r, logic [1:0] md, logic [2:0] rm,
			logic [15:0] disp);
		logic [15:0] base;
		if (md == 2'd0 && rm == RM_DIRECT) return disp;
		unique case (rm)
			3'd0: base = r[3] + r[6];
			3'd1: base = r[3] + r[7];
			3'd2: base = r[5] + r[6];
			3'd3: base = r[5] + r[7];
			3'd4: base = r[6];
			3'd5: base = r[7];
			3'd6: base = r[5];
			default: base = r[3];
		endcase
		if (md == 2'd1) base = base + {{8{disp[7]}}, disp[7:0]};
		else if (md == 2'd2) base = base + disp;
		return base;
	endfunction

	function automatic logic [4:0] ea_clocks(logic [1:0] md, logic [2:0] rm);
		logic wd;
		wd = (md == 2'd1) || (md == 2'd2);
		if (md == 2'd0 && rm == RM_DIRECT) return 5'd6;
		if (rm == 3'd0 || rm == 3'd3) return wd ? 5'd11 : 5'd7;
		if (rm == 3'd1 || rm == 3'd2) return wd ? 5'd12 : 5'd8;
		return wd ? 5'd9 : 5'd5;
	endfunction

endpackage
`default_nettype wire

[sv/x86_16_mov_alu_branch_execute_unit.sv]
`default_nettype none
// Pipeline: an accepted item is held in the execute register and its result is then loaded
// into the output register; the item waits there while the output register awaits the receiver.
// Items do not overlap: the memory read and the write-back of one item complete before
// the next item is accepted and its effective address is formed.
// Reset: registers, IP, flags and clock total clear at once; the byte memory is then swept
// to zero, one even/odd byte pair a cycle over all 2**(MEM_ADDR_BITS-1) rows, no item taken.
module x86_16_mov_alu_branch_execute_unit #(
	parameter int MEM_ADDR_BITS = x86e_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// kind[3:0] wide[4] dest_kind[6:5] dest_reg[10:7] src_kind[12:11] src_reg[16:13]
	// mod_bits[18:17] rm_bits[21:19] displacement[37:22] immediate[53:38] instr_length[56:54]
	input  wire [63:0]  s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// new_ip[15:0] flags_out[21:16] old_value[37:22] new_value[53:38] branch_taken[54]
	// cycle_cost[59:55] clock_total[91:60] error_code[93:92]
	output logic [95:0] m_tdata
);
	import x86e_pkg::*;

	item_t       in_item, item_s1;
	logic        v_s1, accept, advance, clearing;
	regs_t       regs_q;
	logic [15:0] ip_q, ea, ea_s1, mem_rd;
	logic [5:0]  flags_q;
	logic [31:0] sum_q, ea32, wa32;
	logic        out_valid_q;
	logic [95:0] out_q;
	exec_t       res;

	// tdata carries the first field in the lowest bits, the struct in the highest
	assign in_item = {s_tdata[3:0], s_tdata[4], s_tdata[6:5], s_tdata[10:7], s_tdata[12:11],
		s_tdata[16:13], s_tdata[18:17], s_tdata[21:19], s_tdata[37:22], s_tdata[53:38],
		s_tdata[56:54]};
	assign s_tready = !v_s1 && !clearing;
	assign accept = s_tvalid && s_tready;
	assign advance = v_s1 && (!out_valid_q || m_tready);
	assign ea = eff_addr(regs_q, in_item.mod_bits, in_item.rm_bits, in_item.displacement);
	assign ea32 = {16'd0, ea};
	assign wa32 = {16'd0, ea_s1};

	x86e_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(accept), .rd_addr(ea32[MEM_ADDR_BITS-1:0]), .rd_data(mem_rd),
		.wr_en(advance && res.mem_we), .wr_wide(item_s1.wide),
		.wr_addr(wa32[MEM_ADDR_BITS-1:0]), .wr_data(res.new_value),
		.clearing(clearing)
	);

	x86e_exec u_exec (
		.item(item_s1), .regs(regs_q), .mem_data(mem_rd), .ip(ip_q),
		.flags(flags_q), .sum(sum_q), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			regs_q <= '0;
			ip_q <= '0;
			flags_q <= '0;
			sum_q <= '0;
		end else begin
			if (accept) v_s1 <= 1'b1;
			else if (advance) v_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (advance) begin
				ip_q <= res.new_ip;
				flags_q <= res.flags_out;
				sum_q <= res.clock_total;
				if (res.reg_we)
					regs_q <= reg_wr(regs_q, item_s1.dest_reg, item_s1.wide, res.new_value);
				else if (res.cx_we)
					regs_q[1] <= res.new_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			ea_s1 <= ea;
		end
		if (advance)
			out_q <= {2'b00, res.error_code, res.clock_total, res.cycle_cost,
				res.branch_taken, res.new_value, res.old_value, res.flags_out, res.new_ip};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !advance |=> v_s1 && $stable(item_s1))
		else $error("stalled instruction changed");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item not in execute stage");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !v_s1 && !out_valid_q)
		else $error("item in flight during memory clear");
	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost");

endmodule
`default_nettype wire

[sv/x86e_mem.sv]
`default_nettype none
module x86e_mem #(
	parameter int ADDR_BITS = x86e_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  rd_en,
	input  wire [ADDR_BITS-1:0]  rd_addr,
	output logic [15:0]          rd_data,
	input  wire                  wr_en,
	input  wire                  wr_wide,
	input  wire [ADDR_BITS-1:0]  wr_addr,
	input  wire [15:0]           wr_data,
	output logic                 clearing
);
	import x86e_pkg::*;

	localparam int ROW_BITS = ADDR_BITS - 1;
	localparam int ROWS = 1 << ROW_BITS;

	// even bytes in one bank, odd bytes in the other, so a word is one access
	logic [7:0] even_mem [ROWS];
	logic [7:0] odd_mem  [ROWS];
	logic [7:0] even_rd_q, odd_rd_q;
	logic       rd_odd_q;
	logic [ROW_BITS-1:0] clr_q;
	logic       clearing_q;

	logic [ROW_BITS-1:0] rd_row, rd_row_nx, wr_row, wr_row_nx;
	logic        ev_we, od_we;
	logic [ROW_BITS-1:0] ev_row, od_row;
	logic [7:0]  ev_d, od_d;

	assign rd_row    = rd_addr[ADDR_BITS-1:1];
	assign rd_row_nx = rd_row + 1'b1;
	assign wr_row    = wr_addr[ADDR_BITS-1:1];
	assign wr_row_nx = wr_row + 1'b1;
	assign clearing  = clearing_q;

	always_comb begin
		if (clearing_q) begin
			ev_we = 1'b1; od_we = 1'b1;
			ev_row = clr_q; od_row = clr_q;
			ev_d = 8'd0; od_d = 8'd0;
		end else if (!wr_addr[0]) begin
			ev_we = wr_en; od_we = wr_en && wr_wide;
			ev_row = wr_row; od_row = wr_row;
			ev_d = wr_data[7:0]; od_d = wr_data[15:8];
		end else begin
			ev_we = wr_en && wr_wide; od_we = wr_en;
			ev_row = wr_row_nx; od_row = wr_row;
			ev_d = wr_data[15:8]; od_d = wr_data[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ROW_BITS'(ROWS - 1)) clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_we) even_mem[ev_row] <= ev_d;
		if (od_we) odd_mem[od_row] <= od_d;
		if (rd_en) begin
			even_rd_q <= even_mem[rd_addr[0] ? rd_row_nx : rd_row];
			odd_rd_q  <= odd_mem[rd_row];
			rd_odd_q  <= rd_addr[0];
		end
	end

	assign rd_data = rd_odd_q ? {even_rd_q, odd_rd_q} : {odd_rd_q, even_rd_q};

endmodule
`default_nettype wire

[sv/x86e_exec.sv]
`default_nettype none
module x86e_exec (
	input  x86e_pkg::item_t item,
	input  x86e_pkg::regs_t regs,
	input  wire [15:0]      mem_data,
	input  wire [15:0]      ip,
	input  wire [5:0]       flags,
	input  wire [31:0]      sum,
	output x86e_pkg::exec_t res
);
	import x86e_pkg::*;

	logic [15:0] mask, sign, s, d, r, ipa, rel;
	logic [16:0] sum17;
	logic        cf, af, of, taken, mem_used, alu;
	logic [4:0]  base, cost;
	logic [1:0]  err;
	logic [5:0]  fl;
	logic [15:0] cxm;

	always_comb begin
		mask = item.wide ? 16'hffff : 16'h00ff;
		sign = item.wide ? 16'h8000 : 16'h0080;
		ipa  = ip + {13'd0, item.instr_length};
		rel  = {{8{item.immediate[7]}}, item.immediate[7:0]};
		cxm  = regs[1] - 16'd1;
		err  = ERR_OK;
		alu  = item.kind <= K_CMP;
		if (alu) begin
			if (item.dest_kind >= OP_IMM) err = ERR_DEST;
			else if ((item.dest_kind == OP_MEM || item.src_kind == OP_MEM)
					&& item.mod_bits == MOD_REG) err = ERR_MOD3;
		end
		unique case (item.src_kind)
			OP_REG:  s = reg_rd(regs, item.src_reg, item.wide);
			OP_MEM:  s = mem_data & mask;
			OP_IMM:  s = item.immediate & mask;
			default: s = 16'd0;
		endcase
		d = (item.dest_kind == OP_REG) ? reg_rd(regs, item.dest_reg, item.wide)
			: (mem_data & mask);
		sum17 = {1'b0, d} + {1'b0, s};
		if (item.kind == K_MOV) begin
			r = s; cf = 1'b0; af = 1'b0;
		end else if (item.kind == K_ADD) begin
			r = sum17[15:0] & mask;
			cf = item.wide ? sum17[16] : sum17[8];
			af = ({1'b0, d[3:0]} + {1'b0, s[3:0]}) > 5'd15;
		end else begin
			r = (d - s) & mask;
			cf = d < s;
			af = s[3:0] > d[3:0];
		end
		if (item.kind == K_ADD)
			of = ((d ^ s) & sign) == 16'd0 && ((r ^ d) & sign) != 16'd0;
		else
			of = ((d ^ s) & sign) != 16'd0 && ((r ^ d) & sign) != 16'd0;
		fl = flags;
		if (alu && err == ERR_OK && item.kind != K_MOV) begin
			fl[F_CF] = cf;
			fl[F_PF] = ~^r[7:0];
			fl[F_AF] = af;
			fl[F_ZF] = r == 16'd0;
			fl[F_SF] = (r & sign) != 16'd0;
			fl[F_OF] = of;
		end
		base = 5'd0;
		if (item.kind == K_MOV) begin
			if (item.dest_kind == OP_MEM) begin
				if (item.src_kind == OP_REG) base = (item.src_reg == 4'd0) ? 5'd10 : 5'd9;
				else if (item.src_kind == OP_IMM) base = 5'd10;
			end else if (item.src_kind == OP_MEM) base = (item.dest_reg == 4'd0) ? 5'd10 : 5'd8;
			else if (item.src_kind == OP_IMM) base = 5'd4;
			else if (item.src_kind == OP_REG) base = 5'd2;
		end else begin
			if (item.dest_kind == OP_MEM) begin
				if (item.src_kind == OP_IMM) base = 5'd17;
				else if (item.src_kind == OP_REG) base = 5'd16;
			end else if (item.src_kind == OP_MEM) base = 5'd9;
			else if (item.src_kind == OP_REG) base = 5'd3;
			else if (item.src_kind == OP_IMM) base = 5'd4;
		end
		mem_used = item.dest_kind == OP_MEM || item.src_kind == OP_MEM;
		cost = base + (mem_used ? ea_clocks(item.mod_bits, item.rm_bits) : 5'd0);
		unique case (item.kind)
			K_JNE:    taken = !flags[F_ZF];
			K_JE:     taken = flags[F_ZF];
			K_JP:     taken = flags[F_PF];
			K_JB:     taken = flags[F_CF];
			K_LOOPNZ: taken = cxm != 16'd0 && !flags[F_ZF];
			default:  taken = 1'b0;
		endcase

		res = '0;
		res.new_ip = taken ? ipa + rel : ipa;
		res.flags_out = fl;
		res.branch_taken = taken;
		res.error_code = err;
		res.clock_total = sum;
		if (item.kind == K_LOOPNZ) begin
			res.old_value = regs[1];
			res.new_value = cxm;
			res.cx_we = 1'b1;
		end else if (alu && err == ERR_OK) begin
			res.old_value = d;
			res.new_value = r;
			res.reg_we = item.kind != K_CMP && item.dest_kind == OP_REG;
			res.mem_we = item.kind != K_CMP && item.dest_kind == OP_MEM;
			if (item.kind <= K_ADD) begin
				res.cycle_cost = cost;
				res.clock_total = sum + {27'd0, cost};
			end
		end
	end

endmodule
`default_nettype wire
